### hdl/gss_pkg.sv
// Shared types and constants for the gate step sequencer.
package gss_pkg;

    localparam int NUM_STEPS  = 16;
    localparam int PHASE_BITS = 24;
    localparam int PULSE_BITS = 16;
    localparam int STEP_W     = $clog2(NUM_STEPS);
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_EXT_CLOCK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH    = 2'd3;

    // Gate modes; code 3 is undefined and behaves as continuous
    localparam logic [1:0] GATE_TRIGGER    = 2'd0;
    localparam logic [1:0] GATE_RETRIGGER  = 2'd1;
    localparam logic [1:0] GATE_CONTINUOUS = 2'd2;

    localparam logic [1:0]            GATE_MODE_RST       = GATE_TRIGGER;
    localparam logic [PHASE_BITS-1:0] PHASE_INCREMENT_RST = PHASE_BITS'(1522);
    localparam logic [PULSE_BITS-1:0] PULSE_LENGTH_RST    = PULSE_BITS'(44);

    typedef struct packed {
        logic [1:0]            gate_mode;
        logic                  use_external_clock;
        logic [PHASE_BITS-1:0] phase_increment;
        logic [PULSE_BITS-1:0] pulse_length;
    } cfg_t;

    typedef struct packed {
        logic                 run_toggle;
        logic                 reset_edge;
        logic                 ext_clock_edge;
        logic                 note_write;
        logic                 note_clear;
        logic [COUNT_W-1:0]   step_count;
        logic [NUM_STEPS-1:0] button_toggles;
        logic [NUM_STEPS-1:0] jack_toggles;
    } tick_t;

    typedef struct packed {
        logic                 gate_out;
        logic [STEP_W-1:0]    step_index;
        logic                 running;
        logic [NUM_STEPS-1:0] pattern;
        logic                 step_advanced;
    } result_t;

endpackage

### hdl/gss_tick_if.sv
// Valid/ready channel carrying one input tick item.
interface gss_tick_if;
    logic           valid;
    logic           ready;
    gss_pkg::tick_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/gss_result_if.sv
// Valid/ready channel carrying one result item.
interface gss_result_if;
    logic             valid;
    logic             ready;
    gss_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/gss_cfg_regs.sv
// Configuration register file for the gate step sequencer.
module gss_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gss_pkg::CFG_DATA_W-1:0]   cfg_data,
    output gss_pkg::cfg_t                    cfg
);
    import gss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GATE_MODE:       cfg_next.gate_mode          = cfg_data[1:0];
                CFG_USE_EXT_CLOCK:   cfg_next.use_external_clock = cfg_data[0];
                CFG_PHASE_INCREMENT: cfg_next.phase_increment    = cfg_data[PHASE_BITS-1:0];
                CFG_PULSE_LENGTH:    cfg_next.pulse_length       = cfg_data[PULSE_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_mode          <= GATE_MODE_RST;
            cfg_reg.use_external_clock <= 1'b0;
            cfg_reg.phase_increment    <= PHASE_INCREMENT_RST;
            cfg_reg.pulse_length       <= PULSE_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/gss_step_core.sv
// Sequencer state and the per-tick update that forms one result.
module gss_step_core (
    input  logic             clk,
    input  logic             rst_n,
    input  gss_pkg::cfg_t    cfg,
    input  gss_pkg::tick_t   item,
    input  logic             fire,
    output gss_pkg::result_t result
);
    import gss_pkg::*;

    logic                  run_reg,      run_next;
    logic [PHASE_BITS-1:0] phase_reg,    phase_next;
    logic [STEP_W-1:0]     position_reg, position_next;
    logic [NUM_STEPS-1:0]  gate_bits_reg, gate_bits_next;
    logic [PULSE_BITS-1:0] pulse_reg,    pulse_next;

    logic [PHASE_BITS:0]   phase_sum;
    logic                  advance;
    logic [COUNT_W-1:0]    count;
    logic [COUNT_W-1:0]    position_inc;
    logic [NUM_STEPS-1:0]  step_bit;
    logic [NUM_STEPS-1:0]  notes;
    logic [PULSE_BITS-1:0] pulse_load;
    logic                  pulse;
    logic                  gate;

    always_comb
    begin
        run_next  = run_reg ^ item.run_toggle;
        phase_sum = {1'b0, phase_reg} + {1'b0, cfg.phase_increment};
        advance   = 1'b0;
        phase_next = phase_reg;

        if (run_next)
        begin
            if (cfg.use_external_clock)
            begin
                if (item.ext_clock_edge)
                begin
                    phase_next = '0;
                    advance    = 1'b1;
                end
            end
            else
            begin
                advance    = phase_sum[PHASE_BITS];
                phase_next = phase_sum[PHASE_BITS-1:0];
            end
        end

        // Reset restarts at step zero even while stopped
        if (item.reset_edge)
        begin
            phase_next = '0;
            advance    = 1'b1;
        end

        // Clamp the length to 1..NUM_STEPS
        if (item.step_count == '0)
            count = COUNT_W'(1);
        else if (item.step_count > COUNT_W'(NUM_STEPS))
            count = COUNT_W'(NUM_STEPS);
        else
            count = item.step_count;

        position_inc  = COUNT_W'(position_reg) + COUNT_W'(1);
        position_next = position_reg;
        pulse_load    = pulse_reg;
        notes         = gate_bits_reg;

        if (advance)
        begin
            if (item.reset_edge || position_inc >= count)
                position_next = '0;
            else
                position_next = position_inc[STEP_W-1:0];
            pulse_load = cfg.pulse_length;
        end

        step_bit = NUM_STEPS'(1) << position_next;
        if (advance)
        begin
            if (item.note_write)
                notes = notes | step_bit;
            if (item.note_clear)
                notes = notes & ~step_bit;
        end

        pulse      = pulse_load != '0;
        pulse_next = pulse ? pulse_load - PULSE_BITS'(1) : pulse_load;

        gate_bits_next = notes ^ item.button_toggles ^ item.jack_toggles;

        gate = run_next && gate_bits_next[position_next];
        case (cfg.gate_mode)
            GATE_TRIGGER:    gate = gate && pulse;
            GATE_RETRIGGER:  gate = gate && !pulse;
            GATE_CONTINUOUS: gate = gate;
            default:         gate = gate;
        endcase

        result.gate_out      = gate;
        result.step_index    = position_next;
        result.running       = run_next;
        result.pattern       = gate_bits_next;
        result.step_advanced = advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b1;
            phase_reg     <= '0;
            position_reg  <= '0;
            gate_bits_reg <= '0;
            pulse_reg     <= '0;
        end
        else if (fire)
        begin
            run_reg       <= run_next;
            phase_reg     <= phase_next;
            position_reg  <= position_next;
            gate_bits_reg <= gate_bits_next;
            pulse_reg     <= pulse_next;
        end
    end

endmodule

### hdl/gate_step_sequencer.sv
// Top level of the gate step sequencer: input register, step core, result register.
//
// Usage:
//   tick   - sink channel; one item per sample tick carrying edge strobes,
//            note write/clear levels, the requested length and toggle masks.
//   result - source channel; exactly one result item per tick item: gate,
//            current step, run flag, gate pattern and an advance flag.
//   cfg_we/cfg_index/cfg_data - register writes (gate mode, clock source,
//            phase increment, pulse length); write only while idle.
// Path: an accepted tick item lands in the input register and, once the result
//   register is free, is processed and its result registered. Throughput: one
//   item per cycle unless the receiver stalls; the per-tick update is one 25-bit
//   phase add, a step compare and 16-bit mask logic between the two registers.
// Reset (rst_n low): run flag set, phase, step, pattern and pulse counter
//   cleared, registers back to their defaults, both pipeline registers empty.
// Stall: when the receiver holds ready low the result register holds; the
//   input register still takes one more item, then tick.ready drops.
module gate_step_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    gss_tick_if.sink                         tick,
    gss_result_if.source                     result,
    input  logic                             cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gss_pkg::*;

    cfg_t    cfg;
    tick_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    result_t core_result;
    logic    result_free;
    logic    fire;

    gss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the held item into the result register once that slot frees up
    assign result_free = !result_valid_reg || result.ready;
    assign fire        = item_valid_reg && result_free;
    assign tick.ready  = !item_valid_reg || fire;

    gss_step_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item_reg),
        .fire   (fire),
        .result (core_result)
    );

    // Input register: valid bit under reset, payload held without reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            item_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            item_reg <= tick.data;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_free)
        begin
            result_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

endmodule

### tb/tb.sv
// Self-checking testbench for gate_step_sequencer: directed and random ticks against a predictor.
`timescale 1ns / 1ps

module tb;
    import gss_pkg::*;

    // Cycles without any handshake before the run is declared hung; covers the long
    // output hold-off plus generous slack for gaps, drains and register writes.
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    // Input register plus result register, with a little margin.
    localparam int DRAIN_CYCLES = 4;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gss_tick_if   tick_ch ();
    gss_result_if res_ch ();

    gate_step_sequencer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the register file
    logic [1:0]            mode_reg;
    logic                  ext_clk_reg;
    logic [PHASE_BITS-1:0] phase_inc_reg;
    logic [PULSE_BITS-1:0] pulse_len_reg;

    // Predictor copy of the sequencer state
    logic                  seq_run;
    logic [PHASE_BITS-1:0] seq_phase;
    logic [STEP_W-1:0]     seq_pos;
    logic [NUM_STEPS-1:0]  seq_gates;
    logic [PULSE_BITS-1:0] seq_pulse;

    // Results predicted for accepted ticks, oldest first
    result_t pending_results[$];

    // Stimulus knobs; stall_pct and hold_request are shared with the receiver process
    int stall_pct    = 0;
    int hold_request = 0;
    logic [COUNT_W-1:0] stim_len = COUNT_W'(NUM_STEPS);

    int ticks_sent    = 0;
    int results_seen  = 0;
    int advance_count = 0;
    int cfg_writes    = 0;
    int fail_count    = 0;
    int idle_cycles   = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return the predictor to its power-on state and default registers.
    function automatic void reset_sequencer_model();
        mode_reg      = GATE_MODE_RST;
        ext_clk_reg   = 1'b0;
        phase_inc_reg = PHASE_INCREMENT_RST;
        pulse_len_reg = PULSE_LENGTH_RST;
        seq_run       = 1'b1;
        seq_phase     = '0;
        seq_pos       = '0;
        seq_gates     = '0;
        seq_pulse     = '0;
    endfunction

    // Advance the sequencer state by one tick and return the result it produces.
    function automatic result_t next_step_result(input tick_t t);
        logic [PHASE_BITS:0] phase_sum;
        logic [COUNT_W-1:0]  len;
        logic                advance;
        logic                restart;
        logic                pulse_on;
        logic                gate;
        result_t             r;

        advance = 1'b0;
        restart = 1'b0;

        if (t.run_toggle)
            seq_run = ~seq_run;

        // Clock source only counts while running
        if (seq_run)
        begin
            if (ext_clk_reg)
            begin
                if (t.ext_clock_edge)
                begin
                    seq_phase = '0;
                    advance   = 1'b1;
                end
            end
            else
            begin
                phase_sum = {1'b0, seq_phase} + {1'b0, phase_inc_reg};
                advance   = phase_sum[PHASE_BITS];
                seq_phase = phase_sum[PHASE_BITS-1:0];
            end
        end

        // Reset acts even when stopped
        if (t.reset_edge)
        begin
            seq_phase = '0;
            advance   = 1'b1;
            restart   = 1'b1;
        end

        if (advance)
        begin
            len = t.step_count;
            if (len < 1)
                len = COUNT_W'(1);
            if (len > NUM_STEPS)
                len = COUNT_W'(NUM_STEPS);
            if (restart || (seq_pos + 1 >= len))
                seq_pos = '0;
            else
                seq_pos = seq_pos + 1'b1;
            if (t.note_write)
                seq_gates[seq_pos] = 1'b1;
            if (t.note_clear)
                seq_gates[seq_pos] = 1'b0;
            seq_pulse = pulse_len_reg;
            advance_count++;
        end

        pulse_on = (seq_pulse != 0);
        if (pulse_on)
            seq_pulse = seq_pulse - 1'b1;

        seq_gates = seq_gates ^ t.button_toggles ^ t.jack_toggles;

        gate = seq_run && seq_gates[seq_pos];
        if (mode_reg == GATE_TRIGGER)
            gate = gate && pulse_on;
        else if (mode_reg == GATE_RETRIGGER)
            gate = gate && !pulse_on;

        r.gate_out      = gate;
        r.step_index    = seq_pos;
        r.running       = seq_run;
        r.pattern       = seq_gates;
        r.step_advanced = advance;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic bit field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item with nothing expected, actual %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (field_differs("gate_out", 32'(want.gate_out), 32'(got.gate_out)))
                    fail_count++;
                if (field_differs("step_index", 32'(want.step_index), 32'(got.step_index)))
                    fail_count++;
                if (field_differs("running", 32'(want.running), 32'(got.running)))
                    fail_count++;
                if (field_differs("pattern", 32'(want.pattern), 32'(got.pattern)))
                    fail_count++;
                if (field_differs("step_advanced", 32'(want.step_advanced),
                                  32'(got.step_advanced)))
                    fail_count++;
            end
        end
    end

    // Receiver: random stalls at the current rate, plus a long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results still expected",
                     $time, IDLE_LIMIT, pending_results.size());
            $display("gate_step_sequencer verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one tick and hold it until the block takes it; leave valid high so a
    // following call continues the burst without a bubble.
    task automatic send_tick(input tick_t t);
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        pending_results.push_back(next_step_result(t));
        ticks_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        tick_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and hold off until every predicted result has been checked.
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_GATE_MODE:       mode_reg      = value[1:0];
            CFG_USE_EXT_CLOCK:   ext_clk_reg   = value[0];
            CFG_PHASE_INCREMENT: phase_inc_reg = value[PHASE_BITS-1:0];
            CFG_PULSE_LENGTH:    pulse_len_reg = value[PULSE_BITS-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Drain the block, then load all four registers.
    task automatic set_config(input logic [1:0] mode, input logic ext,
                              input logic [PHASE_BITS-1:0] inc,
                              input logic [PULSE_BITS-1:0] plen);
        wait_drained();
        write_cfg(CFG_GATE_MODE, CFG_DATA_W'(mode));
        write_cfg(CFG_USE_EXT_CLOCK, CFG_DATA_W'(ext));
        write_cfg(CFG_PHASE_INCREMENT, CFG_DATA_W'(inc));
        write_cfg(CFG_PULSE_LENGTH, CFG_DATA_W'(plen));
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic tick_t make_tick(input int run, input int rst, input int ext,
                                        input int wr, input int clr, input int len,
                                        input logic [NUM_STEPS-1:0] btn,
                                        input logic [NUM_STEPS-1:0] jack);
        tick_t t;
        t.run_toggle     = 1'(run);
        t.reset_edge     = 1'(rst);
        t.ext_clock_edge = 1'(ext);
        t.note_write     = 1'(wr);
        t.note_clear     = 1'(clr);
        t.step_count     = COUNT_W'(len);
        t.button_toggles = btn;
        t.jack_toggles   = jack;
        return t;
    endfunction

    // Mostly quiet toggle masks, some single-step presses, a few full random words.
    function automatic logic [NUM_STEPS-1:0] random_mask();
        case ($urandom_range(0, 9))
            0, 1:    return NUM_STEPS'(1) << $urandom_range(0, NUM_STEPS - 1);
            2:       return NUM_STEPS'($urandom());
            default: return '0;
        endcase
    endfunction

    // Play-like tick: sparse run and reset presses, a length that changes now and
    // then (occasionally out of range), note levels and button activity.
    function automatic tick_t random_tick();
        tick_t t;
        if ($urandom_range(0, 19) == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                stim_len = COUNT_W'($urandom_range(0, 31));
            else
                stim_len = COUNT_W'($urandom_range(1, NUM_STEPS));
        end
        t.run_toggle     = ($urandom_range(0, 99) < 3);
        t.reset_edge     = ($urandom_range(0, 99) < 3);
        t.ext_clock_edge = ($urandom_range(0, 99) < 35);
        t.note_write     = ($urandom_range(0, 99) < 30);
        t.note_clear     = ($urandom_range(0, 99) < 15);
        t.step_count     = stim_len;
        t.button_toggles = random_mask();
        t.jack_toggles   = random_mask();
        return t;
    endfunction

    // Send ticks in bursts of random length with random gaps in between.
    task automatic run_random(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 20);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                send_tick(random_tick());
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 12));
        end
    endtask

    function automatic logic [PHASE_BITS-1:0] pick_increment();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return PHASE_BITS'(1) << (PHASE_BITS - 1);
            default: return PHASE_BITS'($urandom_range(24'h100000, 24'hFFFFFF));
        endcase
    endfunction

    function automatic logic [PULSE_BITS-1:0] pick_pulse();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return PULSE_BITS'($urandom());
            default: return PULSE_BITS'($urandom_range(1, 8));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default registers: trigger mode, internal clock, slow rate, ~1 ms pulse.
    task automatic test_after_reset();
        stall_pct = 0;
        send_tick(make_tick(0, 0, 0, 0, 0, 16, '0, '0));
        // Restart with a note: step 0 set and a pulse starts
        send_tick(make_tick(0, 1, 0, 1, 0, 16, '0, '0));
        send_tick(make_tick(0, 0, 0, 0, 0, 16, '0, '0));
        send_tick(make_tick(0, 0, 0, 0, 0, 16, '0, 16'h8000));
    endtask

    // Walk the step logic on the external clock in continuous mode.
    task automatic test_step_walk();
        tick_t walk[$];
        set_config(GATE_CONTINUOUS, 1'b1, PHASE_INCREMENT_RST, 16'd3);
        stall_pct = 25;
        walk = '{
            make_tick(0, 0, 1, 1, 0, 16, '0, '0),        // advance and set the new step
            make_tick(0, 0, 1, 1, 1, 16, '0, '0),        // clear beats write
            make_tick(0, 0, 0, 0, 0, 16, '1, '0),        // flip every step from buttons
            make_tick(0, 0, 0, 0, 0, 16, '1, '1),        // button and jack cancel
            make_tick(0, 0, 0, 0, 0, 16, '0, '1),        // flip every step from jacks
            make_tick(0, 0, 1, 0, 0, 31, '0, '0),        // length clamps to sixteen
            make_tick(0, 0, 1, 0, 0, 16, '0, '0),
            make_tick(0, 0, 1, 0, 0, 16, '0, '0),
            make_tick(0, 0, 1, 0, 0, 16, '0, '0),
            make_tick(0, 0, 1, 0, 0, 2, '0, '0),         // length below position wraps
            make_tick(0, 0, 1, 0, 0, 0, '0, '0),         // zero length acts as one
            make_tick(1, 0, 0, 0, 0, 16, '0, '0),        // stop
            make_tick(0, 0, 1, 0, 0, 16, '0, '0),        // clock ignored while stopped
            make_tick(0, 1, 0, 1, 0, 16, '0, '0),        // restart still works stopped
            make_tick(1, 0, 0, 0, 0, 16, '0, '0),        // run again
            make_tick(0, 1, 1, 0, 1, 16, '0, '0),        // restart together with clock
            make_tick(1, 1, 1, 1, 1, 31, '1, 16'h5555)   // everything at once
        };
        foreach (walk[i])
            send_tick(walk[i]);
    endtask

    // Every gate mode, including the undefined code, against short and zero pulses.
    task automatic test_gate_modes();
        logic [PULSE_BITS-1:0] plens[3];
        plens = '{16'd0, 16'd1, 16'd5};
        stall_pct = 20;
        for (int m = 0; m < 4; m++)
        begin
            foreach (plens[p])
            begin
                set_config(2'(m), 1'b1, 24'h400000, plens[p]);
                run_random(12);
            end
        end
    endtask

    // Internal clock at rate extremes; keep the accumulator across settings so the
    // exact-overflow and near-overflow increments see varied starting phases.
    task automatic test_phase_extremes();
        logic [PHASE_BITS-1:0] incs[5];
        incs = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000, 24'hFFFFFF};
        stall_pct = 10;
        foreach (incs[i])
        begin
            set_config(GATE_CONTINUOUS, 1'b0, incs[i], 16'd2);
            run_random(15);
        end
    endtask

    // Many random register settings with varying output stall rates.
    task automatic test_random_settings();
        int stall_rates[4];
        stall_rates = '{0, 10, 40, 75};
        for (int ph = 0; ph < 12; ph++)
        begin
            set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       pick_increment(), pick_pulse());
            stall_pct = stall_rates[$urandom_range(0, 3)];
            run_random(50);
        end
    endtask

    // Hold the output off long enough for the block to fill and stall its input,
    // keep offering ticks, then pause until everything has come out.
    task automatic test_backpressure();
        set_config(GATE_RETRIGGER, 1'b0, 24'hA00000, 16'd4);
        stall_pct    = 0;
        hold_request = LONG_HOLD;
        repeat (40) send_tick(random_tick());
        wait_drained();
        stall_pct = 50;
        run_random(40);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        reset_sequencer_model();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_step_walk();
        test_gate_modes();
        test_phase_extremes();
        test_random_settings();
        test_backpressure();

        wait_drained();

        $display("Run covered %0d tick items, %0d results, %0d step advances, %0d reg writes",
                 ticks_sent, results_seen, advance_count, cfg_writes);
        $display("Settings spanned all gate modes, both clock sources, rate and pulse extremes");
        if (fail_count == 0)
            $display("gate_step_sequencer verification clean");
        else
            $display("gate_step_sequencer verification failed");
        $finish;
    end

endmodule

### gate_step_sequencer.f
hdl/gss_pkg.sv
hdl/gss_tick_if.sv
hdl/gss_result_if.sv
hdl/gss_cfg_regs.sv
hdl/gss_step_core.sv
hdl/gate_step_sequencer.sv
tb/tb.sv
